>>> hdl/tls_pkg.sv
// Package for the traffic light sequencer: command and phase codes, lamp
// encoding, register defaults and the payload and register structs.
// No dependencies; every module of the block imports it.
`timescale 1ns / 1ps

package tls_pkg;

  // Command codes of the input mode field
  typedef enum logic [3:0] {
    MODE_TICK       = 4'd0,
    MODE_OFF        = 4'd1,
    MODE_RED        = 4'd2,
    MODE_GREEN      = 4'd3,
    MODE_TO_GREEN   = 4'd4,
    MODE_TOGGLE     = 4'd5,
    MODE_FAULT      = 4'd6,
    MODE_LAMP_TEST  = 4'd7,
    MODE_RED_FLASH  = 4'd8,
    MODE_FAST_AMBER = 4'd9
  } mode_t;

  typedef enum logic [1:0] {
    PH_RED   = 2'd0,
    PH_AMBER = 2'd1,
    PH_GREEN = 2'd2,
    PH_FAULT = 2'd3
  } phase_t;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TEST_STEP_W = 15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMBER_TRANSITION = 3'd0,
    CFG_FAULT_BLINK      = 3'd1,
    CFG_FLASH_ON         = 3'd2,
    CFG_FLASH_OFF        = 3'd3,
    CFG_FAST_AMBER       = 3'd4,
    CFG_LAMP_TEST_STEP   = 3'd5
  } cfg_idx_t;

  localparam logic [15:0] RST_AMBER_TRANSITION = 16'd4000;
  localparam logic [15:0] RST_FAULT_BLINK      = 16'd500;
  localparam logic [15:0] RST_FLASH_ON         = 16'd400;
  localparam logic [15:0] RST_FLASH_OFF        = 16'd400;
  localparam logic [15:0] RST_FAST_AMBER       = 16'd150;
  localparam logic [TEST_STEP_W-1:0] RST_LAMP_TEST_STEP = 15'd2000;
  localparam logic [TEST_STEP_W-1:0] TEST_STEP_MAX      = 15'd21845;

  // Lamp vector: bit 0 red, bit 1 amber, bit 2 green
  typedef logic [2:0] lamp_t;
  localparam lamp_t LAMP_OFF   = 3'b000;
  localparam lamp_t LAMP_RED   = 3'b001;
  localparam lamp_t LAMP_AMBER = 3'b010;
  localparam lamp_t LAMP_GREEN = 3'b100;

  typedef struct packed {
    logic [15:0]            amber_transition_ms;
    logic [15:0]            fault_blink_ms;
    logic [15:0]            flash_on_ms;
    logic [15:0]            flash_off_ms;
    logic [15:0]            fast_amber_period_ms;
    logic [TEST_STEP_W-1:0] lamp_test_step_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  mode;
    logic [7:0]  flash_count;
    logic [15:0] amber_duration;
  } in_item_t;

  typedef struct packed {
    logic       red_on;
    logic       amber_on;
    logic       green_on;
    logic       barrier_up;
    logic [1:0] light_phase;
    logic       phase_stable;
    logic       signal_busy;
    logic       lamp_test_busy;
  } out_item_t;

  // Red-wins interlock: green is dropped whenever red is requested
  function automatic lamp_t red_wins(lamp_t l);
    red_wins = {l[2] & ~l[0], l[1], l[0]};
  endfunction

  // Barrier opens with green lit or in fault
  function automatic logic barrier_of(lamp_t l, phase_t p);
    barrier_of = l[2] || (p == PH_FAULT);
  endfunction

endpackage

>>> hdl/tls_in_if.sv
// Input channel interface of the traffic light sequencer: valid/ready
// handshake plus the command payload. Standalone, no package needed.
`timescale 1ns / 1ps

interface tls_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  mode;
  logic [7:0]  flash_count;
  logic [15:0] amber_duration;

  modport source (output valid, output mode, output flash_count,
                  output amber_duration, input ready);
  modport sink   (input valid, input mode, input flash_count,
                  input amber_duration, output ready);
endinterface

>>> hdl/tls_out_if.sv
// Result channel interface of the traffic light sequencer: valid/ready
// handshake plus lamp, barrier and status fields. Standalone.
`timescale 1ns / 1ps

interface tls_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       amber_on;
  logic       green_on;
  logic       barrier_up;
  logic [1:0] light_phase;
  logic       phase_stable;
  logic       signal_busy;
  logic       lamp_test_busy;

  modport source (output valid, output red_on, output amber_on, output green_on,
                  output barrier_up, output light_phase, output phase_stable,
                  output signal_busy, output lamp_test_busy, input ready);
  modport sink   (input valid, input red_on, input amber_on, input green_on,
                  input barrier_up, input light_phase, input phase_stable,
                  input signal_busy, input lamp_test_busy, output ready);
endinterface

>>> hdl/traffic_light_sequencer.sv
// Top level of the two-approach work-zone traffic light sequencer.
// Depends on tls_pkg, tls_in_if, tls_out_if, tls_cfg, tls_in_reg, tls_core, tls_out_reg.
//
// Usage:
//   in_ch  - one transaction per command or 1 ms tick (mode, flash_count,
//            amber_duration), valid/ready handshake.
//   out_ch - exactly one transaction per input transaction: lamp states after
//            the red-wins interlock, barrier command, phase and busy flags.
//   cfg_*  - write-only register port (cfg_we, cfg_idx, cfg_wdata); write only
//            while no transaction is in flight. Indexes past the list are ignored.
// Path: the input register loads at the accepting edge and the result
//   register when the transaction advances into it, so a result is offered
//   once it has passed through both registers.
// Throughput: one transaction per cycle while out_ch.ready stays high; the
//   whole update for a transaction is one pass of next-state logic between the input and result registers.
// Reset (rst_n low, synchronous): phase red, lamps off, barrier closed, all
//   timers and signal/test state cleared, registers back to their defaults;
//   both channels come up empty.
// Stall: when out_ch.ready is low the result register holds; the input
//   register still takes one more transaction, then in_ch.ready drops until
//   the result drains. Nothing is lost or repeated.
`timescale 1ns / 1ps

module traffic_light_sequencer #(
  parameter int TIMER_BITS = 16  // elapsed-tick counter width, 12..32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tls_in_if.sink                         in_ch,
  tls_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tls_pkg::*;

  cfg_t      cfg;
  in_item_t  item;
  out_item_t result;
  logic      item_valid;
  logic      can_load;
  logic      adv;

  // Held transaction moves into the result register when that one is free
  // or being taken this cycle; the sequencer state updates on the same edge.
  assign adv = item_valid && can_load;

  tls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tls_in_reg u_in_reg (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .adv   (adv),
    .valid (item_valid),
    .item  (item)
  );

  tls_core #(
    .TIMER_BITS (TIMER_BITS)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (adv),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  tls_out_reg u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (adv),
    .result   (result),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

>>> hdl/tls_cfg.sv
// Configuration register file of the traffic light sequencer.
// Depends on tls_pkg (register indexes, reset values, cfg_t).
`timescale 1ns / 1ps

module tls_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tls_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tls_pkg::cfg_t                  cfg
);
  import tls_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AMBER_TRANSITION: cfg_nxt.amber_transition_ms  = cfg_wdata;
        CFG_FAULT_BLINK:      cfg_nxt.fault_blink_ms       = cfg_wdata;
        CFG_FLASH_ON:         cfg_nxt.flash_on_ms          = cfg_wdata;
        CFG_FLASH_OFF:        cfg_nxt.flash_off_ms         = cfg_wdata;
        CFG_FAST_AMBER:       cfg_nxt.fast_amber_period_ms = cfg_wdata;
        CFG_LAMP_TEST_STEP:   cfg_nxt.lamp_test_step_ms    = cfg_wdata[TEST_STEP_W-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.amber_transition_ms  <= RST_AMBER_TRANSITION;
      cfg_r.fault_blink_ms       <= RST_FAULT_BLINK;
      cfg_r.flash_on_ms          <= RST_FLASH_ON;
      cfg_r.flash_off_ms         <= RST_FLASH_OFF;
      cfg_r.fast_amber_period_ms <= RST_FAST_AMBER;
      cfg_r.lamp_test_step_ms    <= RST_LAMP_TEST_STEP;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/tls_in_reg.sv
// Input register stage of the traffic light sequencer.
// Depends on tls_pkg (in_item_t) and tls_in_if.
`timescale 1ns / 1ps

module tls_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  tls_in_if.sink            in_ch,
  input  logic              adv,    // held item moves to the result stage
  output logic              valid,
  output tls_pkg::in_item_t item
);
  import tls_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;
  logic     take;

  assign in_ch.ready = !valid_r || adv;
  assign take        = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take)     valid_nxt = 1'b1;
    else if (adv) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= '{mode: in_ch.mode, flash_count: in_ch.flash_count,
                  amber_duration: in_ch.amber_duration};
    end
  end

  assign valid = valid_r;
  assign item  = item_r;

endmodule

>>> hdl/tls_core.sv
// Sequencer state and its single-pass next-state logic for one transaction.
// Depends on tls_pkg (codes, lamp helpers, cfg_t, in_item_t, out_item_t).
`timescale 1ns / 1ps

module tls_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  tls_pkg::in_item_t  item,
  input  tls_pkg::cfg_t      cfg,
  output tls_pkg::out_item_t result
);
  import tls_pkg::*;

  // compare width covers both the timers and 16-bit / tripled test steps
  localparam int CMP_W = (TIMER_BITS > 17) ? TIMER_BITS : 17;

  typedef logic [TIMER_BITS-1:0] timer_t;

  phase_t      phase_r, phase_nxt;
  timer_t      phase_tmr_r, phase_tmr_nxt;
  lamp_t       lamp_r, lamp_nxt;
  logic        barrier_r, barrier_nxt;
  lamp_t       saved_r, saved_nxt;
  logic        sig_on_r, sig_on_nxt;
  logic        sig_amber_r, sig_amber_nxt;
  logic        sig_lit_r, sig_lit_nxt;
  logic [7:0]  flashes_r, flashes_nxt;
  timer_t      step_tmr_r, step_tmr_nxt;
  timer_t      total_tmr_r, total_tmr_nxt;
  logic [15:0] sig_len_r, sig_len_nxt;
  logic        fault_amber_r, fault_amber_nxt;
  logic        test_on_r, test_on_nxt;
  timer_t      test_tmr_r, test_tmr_nxt;

  logic [TEST_STEP_W-1:0] test_step;
  logic [CMP_W-1:0]       step1_c, step2_c, step3_c;

  function automatic timer_t sat_inc(timer_t t);
    sat_inc = (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic logic ge16(timer_t t, logic [15:0] c);
    ge16 = CMP_W'(t) >= CMP_W'(c);
  endfunction

  // lamp test boundaries: step, 2*step, 3*step
  assign test_step = (cfg.lamp_test_step_ms > TEST_STEP_MAX) ? TEST_STEP_MAX
                                                             : cfg.lamp_test_step_ms;
  assign step1_c = CMP_W'(test_step);
  assign step2_c = step1_c << 1;
  assign step3_c = step2_c + step1_c;

  always_comb begin
    phase_nxt       = phase_r;
    phase_tmr_nxt   = phase_tmr_r;
    lamp_nxt        = lamp_r;
    barrier_nxt     = barrier_r;
    saved_nxt       = saved_r;
    sig_on_nxt      = sig_on_r;
    sig_amber_nxt   = sig_amber_r;
    sig_lit_nxt     = sig_lit_r;
    flashes_nxt     = flashes_r;
    step_tmr_nxt    = step_tmr_r;
    total_tmr_nxt   = total_tmr_r;
    sig_len_nxt     = sig_len_r;
    fault_amber_nxt = fault_amber_r;
    test_on_nxt     = test_on_r;
    test_tmr_nxt    = test_tmr_r;

    if (fire) begin
      unique case (item.mode)
        MODE_TICK: begin
          phase_tmr_nxt = sat_inc(phase_tmr_r);
          step_tmr_nxt  = sat_inc(step_tmr_r);
          total_tmr_nxt = sat_inc(total_tmr_r);
          test_tmr_nxt  = sat_inc(test_tmr_r);
          if (test_on_r) begin
            // lamp test owns the lamps; the signal and phase steps wait, the timers still count
            if (CMP_W'(test_tmr_nxt) < step1_c) begin
              lamp_nxt = LAMP_RED;
            end else if (CMP_W'(test_tmr_nxt) < step2_c) begin
              lamp_nxt = LAMP_AMBER;
            end else if (CMP_W'(test_tmr_nxt) < step3_c) begin
              lamp_nxt = LAMP_GREEN;
            end else begin
              test_on_nxt = 1'b0;
              saved_nxt   = red_wins(LAMP_RED);
              if (!sig_on_nxt) lamp_nxt = saved_nxt;
            end
            // lamp writes recompute the barrier; a request stored under a
            // running signal leaves it as it was
            if (test_on_nxt || !sig_on_nxt) begin
              barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
            end
          end else begin
            if (sig_on_r) begin
              if (sig_amber_r) begin
                if (ge16(step_tmr_nxt, cfg.fast_amber_period_ms)) begin
                  step_tmr_nxt = '0;
                  sig_lit_nxt  = !sig_lit_r;
                  lamp_nxt     = sig_lit_nxt ? LAMP_AMBER : LAMP_OFF;
                  barrier_nxt  = barrier_of(lamp_nxt, phase_nxt);
                end
                if (ge16(total_tmr_nxt, sig_len_r)) begin
                  sig_on_nxt    = 1'b0;
                  flashes_nxt   = '0;
                  sig_amber_nxt = 1'b0;
                  lamp_nxt      = saved_nxt;
                  barrier_nxt   = barrier_of(lamp_nxt, phase_nxt);
                end
              end else if (sig_lit_r) begin
                if (ge16(step_tmr_nxt, cfg.flash_on_ms)) begin
                  sig_lit_nxt  = 1'b0;
                  lamp_nxt     = LAMP_OFF;
                  barrier_nxt  = barrier_of(lamp_nxt, phase_nxt);
                  step_tmr_nxt = '0;
                  if (flashes_r != '0) flashes_nxt = flashes_r - 1'b1;
                  if (flashes_nxt == '0) begin
                    sig_on_nxt    = 1'b0;
                    sig_amber_nxt = 1'b0;
                    lamp_nxt      = saved_nxt;
                    barrier_nxt   = barrier_of(lamp_nxt, phase_nxt);
                  end
                end
              end else if (ge16(step_tmr_nxt, cfg.flash_off_ms)) begin
                sig_lit_nxt  = 1'b1;
                lamp_nxt     = LAMP_RED;
                barrier_nxt  = barrier_of(lamp_nxt, phase_nxt);
                step_tmr_nxt = '0;
              end
            end
            // phase timing after the signal step
            if (phase_r == PH_AMBER && ge16(phase_tmr_nxt, cfg.amber_transition_ms)) begin
              phase_nxt = PH_GREEN;
              saved_nxt = red_wins(LAMP_GREEN);
              if (!sig_on_nxt) begin
                lamp_nxt    = saved_nxt;
                barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
              end
            end else if (phase_r == PH_FAULT && ge16(phase_tmr_nxt, cfg.fault_blink_ms)) begin
              phase_tmr_nxt   = '0;
              fault_amber_nxt = !fault_amber_r;
              saved_nxt       = red_wins(fault_amber_nxt ? LAMP_AMBER : LAMP_OFF);
              if (!sig_on_nxt) begin
                lamp_nxt    = saved_nxt;
                barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
              end
            end
          end
        end
        MODE_OFF, MODE_RED, MODE_GREEN: begin
          phase_nxt = (item.mode == MODE_GREEN) ? PH_GREEN : PH_RED;
          saved_nxt = red_wins((item.mode == MODE_RED)   ? LAMP_RED :
                               (item.mode == MODE_GREEN) ? LAMP_GREEN : LAMP_OFF);
          if (!sig_on_r) begin
            lamp_nxt    = saved_nxt;
            barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
          end
        end
        MODE_TO_GREEN, MODE_TOGGLE: begin
          if (item.mode == MODE_TO_GREEN || phase_r == PH_RED || phase_r == PH_FAULT) begin
            phase_nxt     = PH_AMBER;
            phase_tmr_nxt = '0;
            saved_nxt     = red_wins(LAMP_AMBER);
            if (!sig_on_r) begin
              lamp_nxt    = saved_nxt;
              barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
            end
          end else if (phase_r == PH_GREEN) begin
            phase_nxt = PH_RED;
            saved_nxt = red_wins(LAMP_RED);
            if (!sig_on_r) begin
              lamp_nxt    = saved_nxt;
              barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
            end
          end
        end
        MODE_FAULT: begin
          phase_nxt     = PH_FAULT;
          phase_tmr_nxt = '0;
          saved_nxt     = red_wins(LAMP_OFF);
          if (!sig_on_r) begin
            lamp_nxt    = saved_nxt;
            barrier_nxt = barrier_of(lamp_nxt, phase_nxt);
          end
        end
        MODE_LAMP_TEST: begin
          test_on_nxt  = 1'b1;
          test_tmr_nxt = '0;
        end
        MODE_RED_FLASH: begin
          if (item.flash_count != '0) begin
            sig_on_nxt    = 1'b1;
            sig_amber_nxt = 1'b0;
            flashes_nxt   = item.flash_count;
            sig_lit_nxt   = 1'b0;
            step_tmr_nxt  = '0;
            total_tmr_nxt = '0;
            lamp_nxt      = LAMP_OFF;
            barrier_nxt   = barrier_of(lamp_nxt, phase_r);
          end
        end
        MODE_FAST_AMBER: begin
          sig_on_nxt    = 1'b1;
          sig_amber_nxt = 1'b1;
          flashes_nxt   = '0;
          sig_lit_nxt   = 1'b1;
          step_tmr_nxt  = '0;
          total_tmr_nxt = '0;
          sig_len_nxt   = item.amber_duration;
          lamp_nxt      = LAMP_AMBER;
          barrier_nxt   = barrier_of(lamp_nxt, phase_r);
        end
        default: ;  // unused codes change nothing
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_RED;
      phase_tmr_r   <= '0;
      lamp_r        <= LAMP_OFF;
      barrier_r     <= 1'b0;
      saved_r       <= LAMP_OFF;
      sig_on_r      <= 1'b0;
      sig_amber_r   <= 1'b0;
      sig_lit_r     <= 1'b0;
      flashes_r     <= '0;
      step_tmr_r    <= '0;
      total_tmr_r   <= '0;
      sig_len_r     <= '0;
      fault_amber_r <= 1'b0;
      test_on_r     <= 1'b0;
      test_tmr_r    <= '0;
    end else begin
      phase_r       <= phase_nxt;
      phase_tmr_r   <= phase_tmr_nxt;
      lamp_r        <= lamp_nxt;
      barrier_r     <= barrier_nxt;
      saved_r       <= saved_nxt;
      sig_on_r      <= sig_on_nxt;
      sig_amber_r   <= sig_amber_nxt;
      sig_lit_r     <= sig_lit_nxt;
      flashes_r     <= flashes_nxt;
      step_tmr_r    <= step_tmr_nxt;
      total_tmr_r   <= total_tmr_nxt;
      sig_len_r     <= sig_len_nxt;
      fault_amber_r <= fault_amber_nxt;
      test_on_r     <= test_on_nxt;
      test_tmr_r    <= test_tmr_nxt;
    end
  end

  // result reflects the state after this transaction
  assign result = '{red_on:         lamp_nxt[0],
                    amber_on:       lamp_nxt[1],
                    green_on:       lamp_nxt[2],
                    barrier_up:     barrier_nxt,
                    light_phase:    phase_nxt,
                    phase_stable:   phase_nxt != PH_AMBER,
                    signal_busy:    sig_on_nxt,
                    lamp_test_busy: test_on_nxt};

`ifndef NO_ASSERTIONS
  a_no_red_green: assert property (@(posedge clk) disable iff (!rst_n)
    !(lamp_r[0] && lamp_r[2]))
    else $error("red and green lit together");

  a_idle_sig_no_flashes: assert property (@(posedge clk) disable iff (!rst_n)
    !sig_on_r |-> (flashes_r == '0 && !sig_amber_r))
    else $error("signal state left over after signal end");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> ($stable(phase_r) && $stable(lamp_r) && $stable(phase_tmr_r)))
    else $error("state changed without a transaction");

  a_saved_interlocked: assert property (@(posedge clk) disable iff (!rst_n)
    !(saved_r[0] && saved_r[2]))
    else $error("stored lamps violate red-wins interlock");
`endif

endmodule

>>> hdl/tls_out_reg.sv
// Result register of the traffic light sequencer; drives the result channel.
// Depends on tls_pkg (out_item_t) and tls_out_if.
`timescale 1ns / 1ps

module tls_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tls_pkg::out_item_t result,
  output logic               can_load,
  tls_out_if.source          out_ch
);
  import tls_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign can_load = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load)              valid_nxt = 1'b1;
    else if (out_ch.ready) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.red_on         = data_r.red_on;
  assign out_ch.amber_on       = data_r.amber_on;
  assign out_ch.green_on       = data_r.green_on;
  assign out_ch.barrier_up     = data_r.barrier_up;
  assign out_ch.light_phase    = data_r.light_phase;
  assign out_ch.phase_stable   = data_r.phase_stable;
  assign out_ch.signal_busy    = data_r.signal_busy;
  assign out_ch.lamp_test_busy = data_r.lamp_test_busy;

endmodule
